>>> hdl/sprite_screen_projection_unit_defines.svh
// Assertion macros for the sprite projection RTL.
// Needs clk in the scope of each use, and rst_n as well for SSPU_ASSERT.
`ifndef SPRITE_SCREEN_PROJECTION_UNIT_DEFINES_SVH
`define SPRITE_SCREEN_PROJECTION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SSPU_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  prop) else $error("sspu assertion failed");
`define SSPU_ASSERT_NORST(lbl, prop) lbl: assert property (@(posedge clk) prop) \
  else $error("sspu reset assertion failed");
`else
`define SSPU_ASSERT(lbl, prop)
`define SSPU_ASSERT_NORST(lbl, prop)
`endif
`endif

>>> hdl/sspu_pkg.sv
// Types and constants for the sprite screen projection unit.
// No dependencies.
package sspu_pkg;

  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;

  localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd480;

  typedef struct packed {
    logic signed [31:0] sprite_x;
    logic signed [31:0] sprite_y;
    logic signed [31:0] cam_pos_x;
    logic signed [31:0] cam_pos_y;
    logic signed [31:0] cam_dir_x;
    logic signed [31:0] cam_dir_y;
    logic signed [31:0] cam_plane_x;
    logic signed [31:0] cam_plane_y;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] centre_column;
    logic        [14:0] sprite_size;
    logic        [11:0] row_start;
    logic        [11:0] row_end;
    logic        [15:0] column_start;
    logic signed [15:0] column_end;
    logic signed [31:0] depth;
    logic               in_front;
    logic               singular_camera;
  } out_item_t;

endpackage

>>> hdl/sspu_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Stand-alone; used by sprite_screen_projection_unit.
module sspu_div #(
  parameter int NW = 83,
  parameter int DW = 64,
  parameter int QW = 31,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic          ovf,
  output logic [SW-1:0] out_side
);

  localparam int CW = NW + DW + QW;

  logic          vld_r  [QW+1];
  logic [CW-1:0] rem_r  [QW+1];
  logic [DW-1:0] den_r  [QW+1];
  logic [QW-1:0] q_r    [QW+1];
  logic          ovf_r  [QW+1];
  logic [SW-1:0] side_r [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= CW'(num);
      den_r[0]  <= den;
      q_r[0]    <= '0;
      ovf_r[0]  <= CW'(num) >= (CW'(den) << QW);
      side_r[0] <= side;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [CW-1:0] sub_w;
    logic          ge_w;
    logic [CW-1:0] rem_nxt;
    logic [QW-1:0] q_nxt;

    always_comb begin
      sub_w   = CW'(den_r[k-1]) << (QW - k);
      ge_w    = rem_r[k-1] >= sub_w;
      rem_nxt = ge_w ? rem_r[k-1] - sub_w : rem_r[k-1];
      q_nxt   = q_r[k-1];
      q_nxt[QW-k] = ge_w;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_r[k-1];
        q_r[k]    <= q_nxt;
        ovf_r[k]  <= ovf_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[QW];
  assign quo       = q_r[QW];
  assign ovf       = ovf_r[QW];
  assign out_side  = side_r[QW];

endmodule

>>> hdl/sprite_screen_projection_unit.sv
// Sprite screen projection pipeline: camera transform, depth division, clipping.
// Depends on sspu_pkg, sspu_div and sprite_screen_projection_unit_defines.svh.
//
//   channel | dir | handshake         | payload
//   in      | in  | in_valid/in_stall | sspu_pkg::in_item_t
//   out     | out | out_valid/out_stall| sspu_pkg::out_item_t
//   cfg     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One request per cycle unless a stalled result holds the pipeline; four front stages, 32-stage
// transform divider, three middle stages, 16-stage projection divider, two back stages.
// Reset clears all valid bits and loads the screen size defaults.
// A stalled result halts the whole pipeline; nothing is dropped or repeated.
`include "sprite_screen_projection_unit_defines.svh"
module sprite_screen_projection_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sspu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sspu_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [12:0]         cfg_data
);

  localparam int NW1 = 67 + FRAC_BITS;
  localparam int NWS = 13 + FRAC_BITS;
  localparam logic signed [33:0] HALF = 34'sd1 <<< (FRAC_BITS - 1);

  logic [12:0] w_r, h_r;
  logic [11:0] hw, hh;
  logic        adv;

  assign cfg_ready = 1'b1;
  assign hw = w_r[12:1];
  assign hh = h_r[12:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= sspu_pkg::SCREEN_WIDTH_RST;
      h_r <= sspu_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sspu_pkg::REG_SCREEN_WIDTH:  w_r <= cfg_data;
        sspu_pkg::REG_SCREEN_HEIGHT: h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign out_valid = out_valid_r;

  // front stages
  logic               v1_r, v2_r, v3_r, v4_r;
  logic signed [33:0] rx_r, ry_r;
  logic signed [31:0] dx_r, dy_r, px_r, py_r;
  logic signed [65:0] a_r, b_r, e_r, f_r;
  logic signed [63:0] c_r, d_r;
  logic signed [66:0] numx_r, numy_r;
  logic signed [63:0] det_r;
  logic [66:0]        magx_r, magy_r;
  logic [63:0]        magd_r;
  logic               negx_r, negy_r, sing4_r;
  logic signed [33:0] rx_nxt, ry_nxt;

  always_comb begin
    rx_nxt = 34'(in_data.sprite_x) - 34'(in_data.cam_pos_x) + HALF;
    ry_nxt = 34'(in_data.sprite_y) - 34'(in_data.cam_pos_y) + HALF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rx_r   <= rx_nxt;
      ry_r   <= ry_nxt;
      dx_r   <= in_data.cam_dir_x;
      dy_r   <= in_data.cam_dir_y;
      px_r   <= in_data.cam_plane_x;
      py_r   <= in_data.cam_plane_y;
      a_r    <= 66'(dy_r) * 66'(rx_r);
      b_r    <= 66'(dx_r) * 66'(ry_r);
      e_r    <= 66'(px_r) * 66'(ry_r);
      f_r    <= 66'(py_r) * 66'(rx_r);
      c_r    <= 64'(px_r) * 64'(dy_r);
      d_r    <= 64'(dx_r) * 64'(py_r);
      numx_r <= 67'(a_r) - 67'(b_r);
      numy_r <= 67'(e_r) - 67'(f_r);
      det_r  <= c_r - d_r;
      magx_r <= numx_r[66] ? 67'(-numx_r) : 67'(numx_r);
      magy_r <= numy_r[66] ? 67'(-numy_r) : 67'(numy_r);
      magd_r <= det_r[63] ? 64'(-det_r) : 64'(det_r);
      negx_r <= numx_r[66] ^ det_r[63];
      negy_r <= numy_r[66] ^ det_r[63];
      sing4_r <= det_r == 64'sd0;
    end
  end

  // transform dividers
  logic          dv_valid;
  logic [30:0]   qx, qy;
  logic          ovfx, ovfy;
  logic          sx_neg;
  logic [1:0]    sy_side;

  sspu_div #(.NW(NW1), .DW(64), .QW(31), .SW(1)) u_div_tx (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v4_r),
    .num(NW1'(magx_r) << FRAC_BITS), .den(magd_r), .side(negx_r),
    .out_valid(), .quo(qx), .ovf(ovfx), .out_side(sx_neg)
  );

  sspu_div #(.NW(NW1), .DW(64), .QW(31), .SW(2)) u_div_ty (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v4_r),
    .num(NW1'(magy_r) << FRAC_BITS), .den(magd_r), .side({negy_r, sing4_r}),
    .out_valid(dv_valid), .quo(qy), .ovf(ovfy), .out_side(sy_side)
  );

  logic signed [31:0] tx_nxt, ty_nxt;

  always_comb begin
    if (sy_side[0]) begin
      tx_nxt = '0;
      ty_nxt = '0;
    end else begin
      if (ovfx) tx_nxt = sx_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      else      tx_nxt = sx_neg ? 32'(-{1'b0, qx}) : 32'({1'b0, qx});
      if (ovfy) ty_nxt = sy_side[1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      else      ty_nxt = sy_side[1] ? 32'(-{1'b0, qy}) : 32'({1'b0, qy});
    end
  end

  // middle stages
  logic               v5_r, v6_r, v7_r;
  logic signed [31:0] tx5_r, ty5_r, ty6_r, ty7_r;
  logic               sing5_r, sing6_r, sing7_r;
  logic signed [45:0] cnum_r;
  logic [44:0]        magc_r;
  logic [31:0]        magt_r;
  logic               negc_r, cpos_r, cneg_r, tyz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (adv) begin
      v5_r <= dv_valid;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tx5_r   <= tx_nxt;
      ty5_r   <= ty_nxt;
      sing5_r <= sy_side[0];
      cnum_r  <= 46'($signed({1'b0, hw})) * (46'(tx5_r) + 46'(ty5_r));
      ty6_r   <= ty5_r;
      sing6_r <= sing5_r;
      magc_r  <= cnum_r[45] ? 45'(-cnum_r) : 45'(cnum_r);
      negc_r  <= cnum_r[45] ^ ty6_r[31];
      cneg_r  <= cnum_r[45];
      cpos_r  <= !cnum_r[45] && (cnum_r != 46'sd0);
      magt_r  <= ty6_r[31] ? 32'(-ty6_r) : 32'(ty6_r);
      tyz_r   <= ty6_r == 32'sd0;
      ty7_r   <= ty6_r;
      sing7_r <= sing6_r;
    end
  end

  // projection dividers
  logic               pv_valid;
  logic [14:0]        qc, qs;
  logic               ovfc, ovfs;
  logic [35:0]        c_side;
  logic               s_tyz;

  sspu_div #(.NW(45), .DW(32), .QW(15), .SW(36)) u_div_cx (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v7_r),
    .num(magc_r), .den(magt_r), .side({negc_r, cpos_r, cneg_r, ty7_r, sing7_r}),
    .out_valid(pv_valid), .quo(qc), .ovf(ovfc), .out_side(c_side)
  );

  sspu_div #(.NW(NWS), .DW(32), .QW(15), .SW(1)) u_div_sz (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v7_r),
    .num(NWS'(h_r) << FRAC_BITS), .den(magt_r), .side(tyz_r),
    .out_valid(), .quo(qs), .ovf(ovfs), .out_side(s_tyz)
  );

  logic signed [15:0] cx_nxt;
  logic [14:0]        size_nxt;

  always_comb begin
    if (s_tyz) begin
      if (c_side[34])      cx_nxt = 16'sh7FFF;
      else if (c_side[33]) cx_nxt = 16'sh8000;
      else                 cx_nxt = 16'($signed({1'b0, hw}));
    end else if (ovfc) begin
      cx_nxt = c_side[35] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      cx_nxt = c_side[35] ? 16'(-{1'b0, qc}) : 16'({1'b0, qc});
    end
    size_nxt = (s_tyz || ovfs) ? 15'h7FFF : qs;
  end

  // back stages
  logic               v8_r;
  logic signed [15:0] cx8_r;
  logic [14:0]        size8_r;
  logic signed [31:0] ty8_r;
  logic               sing8_r;
  sspu_pkg::out_item_t out_r, out_nxt;
  logic [13:0]        half;
  logic signed [14:0] rs;
  logic [14:0]        re;
  logic signed [17:0] cs, ce;

  always_comb begin
    half = size8_r[14:1];
    rs   = $signed({3'b0, hh}) - $signed({1'b0, half});
    re   = 15'(hh) + 15'(half);
    cs   = 18'(cx8_r) - $signed({4'b0, half});
    ce   = 18'(cx8_r) + $signed({4'b0, half});
    out_nxt.centre_column   = cx8_r;
    out_nxt.sprite_size     = size8_r;
    out_nxt.row_start       = rs[14] ? 12'd0 : rs[11:0];
    out_nxt.row_end         = (re >= 15'(h_r)) ? 12'(h_r - 13'd1) : re[11:0];
    out_nxt.column_start    = cs[17] ? 16'd0 : cs[15:0];
    out_nxt.column_end      = (ce >= $signed({5'b0, w_r})) ? 16'(16'(w_r) - 16'd1)
                                                          : ce[15:0];
    out_nxt.depth           = ty8_r;
    out_nxt.in_front        = !ty8_r[31] && (ty8_r != 32'sd0);
    out_nxt.singular_camera = sing8_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v8_r        <= pv_valid;
      out_valid_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx8_r   <= cx_nxt;
      size8_r <= size_nxt;
      ty8_r   <= c_side[32:1];
      sing8_r <= c_side[0];
      out_r   <= out_nxt;
    end
  end

  assign out_data = out_r;

  `SSPU_ASSERT(a_sing_depth, out_valid_r && out_r.singular_camera |-> out_r.depth == 32'sd0)
  `SSPU_ASSERT(a_row_start, out_valid_r |-> out_r.row_start <= hh)
  `SSPU_ASSERT(a_stall_hold, out_valid_r && out_stall |=> out_valid_r && $stable(out_r))
  `SSPU_ASSERT_NORST(a_reset_clear, !rst_n |=> !out_valid_r && !v8_r)

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for sprite_screen_projection_unit: a directed table, then random
// requests checked against a built-in projection predictor. Depends on sspu_pkg and the RTL.
`timescale 1ns / 100ps
module tb_top;

  typedef struct {
    sspu_pkg::in_item_t  item;
    bit                  typed;
    sspu_pkg::out_item_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  sspu_pkg::in_item_t  in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  sspu_pkg::out_item_t out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  logic [12:0] scr_w, scr_h;
  sspu_pkg::out_item_t proj_q[$];
  int          fail_cnt = 0;
  int          burst_left = 0;
  int          hold_cycles = 0;
  bit          hold_req = 1'b0;

  always #5 clk = ~clk;

  sprite_screen_projection_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

  function automatic longint depth_div(logic signed [127:0] num, logic signed [127:0] den);
    logic        neg;
    logic [127:0] n, d, q, lim;
    neg = (num < 0) ^ (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (n << 16) / d;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) q = lim;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic sspu_pkg::out_item_t project(sspu_pkg::in_item_t x, logic [12:0] w13,
                                                  logic [12:0] h13);
    logic signed [127:0] rx, ry, dx, dy, px, py, det;
    longint tx, ty, w, h, hw, hh, cnum, cx, size, rs, re, cs, ce;
    sspu_pkg::out_item_t r;
    rx = $signed(x.sprite_x);
    rx = rx - $signed(x.cam_pos_x) + 32768;
    ry = $signed(x.sprite_y);
    ry = ry - $signed(x.cam_pos_y) + 32768;
    dx = $signed(x.cam_dir_x);
    dy = $signed(x.cam_dir_y);
    px = $signed(x.cam_plane_x);
    py = $signed(x.cam_plane_y);
    w = w13; h = h13; hw = w / 2; hh = h / 2;
    det = px * dy - dx * py;
    tx = 0; ty = 0;
    if (det != 0) begin
      tx = depth_div(dy * rx - dx * ry, det);
      ty = depth_div(px * ry - py * rx, det);
    end
    cnum = hw * (ty + tx);
    if (ty != 0) cx = cnum / ty;
    else cx = (cnum > 0) ? 32767 : ((cnum < 0) ? -32768 : hw);
    if (cx > 32767) cx = 32767;
    if (cx < -32768) cx = -32768;
    if (ty == 0) size = 32767;
    else begin
      size = (h << 16) / ((ty < 0) ? -ty : ty);
      if (size > 32767) size = 32767;
    end
    rs = hh - size / 2;
    if (rs < 0) rs = 0;
    re = hh + size / 2;
    if (re >= h) re = h - 1;
    cs = cx - size / 2;
    if (cs < 0) cs = 0;
    ce = cx + size / 2;
    if (ce >= w) ce = w - 1;
    r.centre_column   = cx[15:0];
    r.sprite_size     = size[14:0];
    r.row_start       = rs[11:0];
    r.row_end         = re[11:0];
    r.column_start    = cs[15:0];
    r.column_end      = ce[15:0];
    r.depth           = ty[31:0];
    r.in_front        = ty > 0;
    r.singular_camera = det == 0;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_cnt++;
  endtask

  task automatic cmp(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report(what, got, want);
  endtask

  always @(posedge clk) begin
    sspu_pkg::out_item_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (proj_q.size() == 0) report("unexpected result", out_data[31:0], '0);
      else begin
        w = proj_q.pop_front();
        cmp("centre_column", 32'(out_data.centre_column), 32'(w.centre_column));
        cmp("sprite_size", 32'(out_data.sprite_size), 32'(w.sprite_size));
        cmp("row_start", 32'(out_data.row_start), 32'(w.row_start));
        cmp("row_end", 32'(out_data.row_end), 32'(w.row_end));
        cmp("column_start", 32'(out_data.column_start), 32'(w.column_start));
        cmp("column_end", 32'(out_data.column_end), 32'(w.column_end));
        cmp("depth", out_data.depth, w.depth);
        cmp("in_front", 32'(out_data.in_front), 32'(w.in_front));
        cmp("singular_camera", 32'(out_data.singular_camera), 32'(w.singular_camera));
      end
    end
  end

  // receiver stall pattern, with one long hold on request
  initial begin
    int mode, left;
    mode = 0; left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cycles = 400;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 200);
      end
      left--;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  task automatic send_req(sspu_pkg::in_item_t it, bit typed, sspu_pkg::out_item_t want);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    proj_q.push_back(typed ? want : project(it, scr_w, scr_h));
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (proj_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == sspu_pkg::REG_SCREEN_WIDTH) scr_w = val;
    else if (idx == sspu_pkg::REG_SCREEN_HEIGHT) scr_h = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rnd_word(bit unitish);
    int m;
    m = $urandom_range(0, 9);
    if (m == 0) return $urandom;
    if (m == 1) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (unitish) return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    return $urandom_range(0, 32'h0028_0000) - 32'h0014_0000;
  endfunction

  function automatic sspu_pkg::in_item_t rnd_item;
    sspu_pkg::in_item_t it;
    if ($urandom_range(0, 9) == 0) begin
      it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      it.sprite_x    = rnd_word(1'b0);
      it.sprite_y    = rnd_word(1'b0);
      it.cam_pos_x   = rnd_word(1'b0);
      it.cam_pos_y   = rnd_word(1'b0);
      it.cam_dir_x   = rnd_word(1'b1);
      it.cam_dir_y   = rnd_word(1'b1);
      it.cam_plane_x = rnd_word(1'b1);
      it.cam_plane_y = rnd_word(1'b1);
    end
    return it;
  endfunction

  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] NONE = 32'hFFFF_0000;
  localparam logic [31:0] PLN  = 32'h0000_A8F6;
  localparam logic [31:0] MAXW = 32'h7FFF_FFFF;
  localparam logic [31:0] MINW = 32'h8000_0000;

  stim_row_t dir_tab[$];

  initial begin
    stim_row_t row;
    logic [12:0] ws[6], hs[6];
    ws = '{13'd640, 13'd1, 13'd4096, 13'd0, 13'd8191, 13'd320};
    hs = '{13'd480, 13'd1, 13'd4096, 13'd0, 13'd8191, 13'd200};
    scr_w = sspu_pkg::SCREEN_WIDTH_RST;
    scr_h = sspu_pkg::SCREEN_HEIGHT_RST;

    row.typed = 1'b1;
    row.item = '{32'h0003_0000, 32'h0005_0000, ONE, ONE, ONE, ONE, ONE, ONE};
    row.want = '{16'sd320, 15'd32767, 12'd0, 12'd479, 16'd0, 16'sd639, 32'sd0, 1'b0, 1'b1};
    dir_tab.push_back(row);
    row.item = '0;
    dir_tab.push_back(row);
    row.typed = 1'b0;
    row.item = '{32'h0005_0000, 32'h0008_0000, 32'h0005_0000, ONE, 0, ONE, PLN, 0};
    dir_tab.push_back(row);
    row.item = '{32'h0005_0000, 32'h0001_0000, 32'h0005_0000, 32'h0008_0000, 0, ONE, PLN, 0};
    dir_tab.push_back(row);
    row.item = '{32'h0004_0000, MINW, 32'h0004_0000, 0, 0, ONE, PLN, 0};
    dir_tab.push_back(row);
    row.item = '{0, 32'hFFFF_8000, 0, 0, ONE, ONE, ONE, 0};
    dir_tab.push_back(row);
    row.item = '{MAXW, MAXW, MINW, MINW, MAXW, MAXW, MAXW, MINW};
    dir_tab.push_back(row);
    row.item = '{MINW, MINW, MAXW, MAXW, MINW, MINW, MINW, MAXW};
    dir_tab.push_back(row);
    row.item = '{MAXW, MINW, MAXW, MINW, 1, 1, 1, 0};
    dir_tab.push_back(row);
    row.item = '{32'h0100_0000, 32'h0100_0000, 0, 0, 0, 1, 1, 0};
    dir_tab.push_back(row);
    row.item = '{32'h0002_0000, 32'h0003_0000, 0, 0, NONE, 0, 0, PLN};
    dir_tab.push_back(row);
    row.item = '{32'h0002_0000, 32'h0003_0000, 0, 0, 0, NONE, NONE, 0};
    dir_tab.push_back(row);
    row.item = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 1, 1, 1};
    dir_tab.push_back(row);
    row.item = '{32'h0000_8000, 32'h0064_0000, 0, 0, 0, ONE, ONE, 0};
    dir_tab.push_back(row);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_req(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
    drain();
    write_reg(2'd2, 13'h1FFF);
    write_reg(2'd3, 13'h0AAA);

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        drain();
        write_reg(sspu_pkg::REG_SCREEN_WIDTH, ws[p]);
        write_reg(sspu_pkg::REG_SCREEN_HEIGHT, hs[p]);
      end
      for (int n = 0; n < 260; n++) begin
        if (p == 0 && n == 100) hold_req = 1'b1;
        send_req(rnd_item(), 1'b0, '0);
      end
    end
    drain();
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
